>>> design/clb_pkg.sv
// ----------------------------------------------------------------------------
// Collector load balancer package
// Shared widths, register and mode codes, and the divider request and
// response structs used between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int MAX_COLLECTORS_DEF = 8;

  localparam int WEIGHT_COUNT = 8;
  localparam int WEIGHT_W     = 8;
  localparam int WEIGHT_SHIFT = 8;
  localparam int DIVIDEND_W   = 16;
  localparam int COUNT_W      = 32;
  localparam int DIVISOR_W    = 33;
  localparam int ACTIVE_W     = 4;
  localparam int MODE_W       = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 64;
  localparam int OUT_INDEX_W  = 3;
  localparam int REL_INDEX_W  = 3;

  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEAST       = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WEIGHTED    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNSUPPORTED = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_BALANCE_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHTS      = 2'd2;

  localparam logic KIND_PICK    = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [DIVIDEND_W-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/clb_ram.sv
// ----------------------------------------------------------------------------
// Collector load balancer RAM
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module clb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/clb_div.sv
// ----------------------------------------------------------------------------
// Collector load balancer divider
// Restoring divider, one quotient bit per cycle, returning quotient and
// remainder of a 16-bit dividend by a 33-bit divisor.
// ----------------------------------------------------------------------------
module clb_div (
  input  logic              clk,
  input  logic              rst_n,
  input  clb_pkg::div_req_t req,
  output clb_pkg::div_rsp_t rsp
);

  localparam int DW = clb_pkg::DIVIDEND_W;
  localparam int VW = clb_pkg::DIVISOR_W;
  localparam int SW = $clog2(DW + 1);
  localparam logic [SW-1:0] STEPS = SW'(DW);

  logic [DW-1:0] dvd_r;
  logic [VW-1:0] dvs_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] quo_r;
  logic [SW-1:0] steps_r;
  logic          active_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic          fits;

  assign shifted = {rem_r[DW-1:0], dvd_r[DW-1]};
  assign fits    = {{(VW-DW-1){1'b0}}, shifted} >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
      end else if (active_r && steps_r == SW'(1)) begin
        active_r <= 1'b0;
        done_r   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r   <= req.dividend;
      dvs_r   <= req.divisor;
      rem_r   <= '0;
      quo_r   <= '0;
      steps_r <= STEPS;
    end else if (active_r) begin
      dvd_r   <= {dvd_r[DW-2:0], 1'b0};
      rem_r   <= fits ? (shifted - dvs_r[DW:0]) : shifted;
      quo_r   <= {quo_r[DW-2:0], fits};
      steps_r <= steps_r - SW'(1);
    end
  end

  assign rsp.busy      = active_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r[DW-1:0];

endmodule

>>> design/collector_load_balancer_unit.sv
// ----------------------------------------------------------------------------
// Collector load balancer unit
// Picks a collector for each new session and keeps per-collector session
// counts; supports round robin, least sessions and weighted selection.
// ----------------------------------------------------------------------------
// Usage: an input transaction (in_kind, in_release_index) is taken on a rising
// edge with start high and busy low. A pick (in_kind 0) yields exactly one
// result transaction: out_strobe is high for one cycle with out_chosen_index
// and out_choice_valid. A release (in_kind 1) yields no result.
// Steps, with n the effective collector count:
//   release                  count read, then count write
//   unsupported mode pick    never busy, result in the next cycle
//   round robin pick         one pass of the divider for the turn modulo
//                            n, then count update
//   least sessions pick      one count read per collector, then count update
//   weighted pick            one count read and one pass of the shared
//                            divider per collector, then count update
// The result strobe follows the last busy cycle. The receiver cannot stall:
// each result is offered for exactly one cycle. Configuration writes take
// effect at once and belong to idle periods. Reset clears all session counts
// through per-entry valid bits, the round robin turn and the registers.
// ----------------------------------------------------------------------------
module collector_load_balancer_unit #(
  parameter int MAX_COLLECTORS = clb_pkg::MAX_COLLECTORS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_kind,
  input  logic [clb_pkg::REL_INDEX_W-1:0]    in_release_index,
  output logic                               out_strobe,
  output logic [clb_pkg::OUT_INDEX_W-1:0]    out_chosen_index,
  output logic                               out_choice_valid,
  input  logic                               cfg_we,
  input  logic [clb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [clb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Index width for the count store and a wider width for comparing an index
  // plus one against the effective count.
  localparam int IW = (MAX_COLLECTORS > 1) ? $clog2(MAX_COLLECTORS) : 1;
  localparam int NW = ((IW + 1) > clb_pkg::ACTIVE_W) ? (IW + 1) : clb_pkg::ACTIVE_W;
  localparam int CW = clb_pkg::COUNT_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_RR_DIV   = 4'd1;
  localparam logic [3:0] ST_SCAN_RD  = 4'd2;
  localparam logic [3:0] ST_SCAN_CMP = 4'd3;
  localparam logic [3:0] ST_SCAN_DIV = 4'd4;
  localparam logic [3:0] ST_INC_RD   = 4'd5;
  localparam logic [3:0] ST_INC_WR   = 4'd6;
  localparam logic [3:0] ST_REL_RD   = 4'd7;
  localparam logic [3:0] ST_REL_WR   = 4'd8;

  // Configuration registers.
  logic [clb_pkg::MODE_W-1:0]     mode_r;
  logic [clb_pkg::ACTIVE_W-1:0]   active_r;
  logic [clb_pkg::CFG_DATA_W-1:0] weights_r;

  // Sequencer state.
  logic [3:0]            state_r, state_nxt;
  logic [IW-1:0]         turn_r, turn_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         sel_r, sel_nxt;
  logic [IW-1:0]         addr_r, addr_nxt;
  logic [CW-1:0]         best_r, best_nxt;
  logic [MAX_COLLECTORS-1:0] vld_r;

  logic                            out_strobe_r, out_strobe_nxt;
  logic [clb_pkg::OUT_INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic                            out_cv_r, out_cv_nxt;

  // Count store and shared divider.
  logic          ram_we;
  logic [CW-1:0] ram_wdata;
  logic [CW-1:0] ram_q;
  clb_pkg::div_req_t div_req;
  clb_pkg::div_rsp_t div_rsp;

  // Datapath helpers.
  logic [clb_pkg::ACTIVE_W-1:0] n_eff;
  logic [CW-1:0]                cnt_rd;
  logic [CW-1:0]                cnt_inc;
  logic [CW-1:0]                score;
  logic [clb_pkg::WEIGHT_W-1:0] weight_cur;
  logic                         idx_last;
  logic                         take_least;
  logic                         take_weight;
  logic [IW-1:0]                rr_sel;
  logic                         rr_wrap;

  clb_ram #(
    .WIDTH(CW),
    .DEPTH(MAX_COLLECTORS)
  ) u_count_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr_r),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(ram_q)
  );

  clb_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  // An active_count of zero acts as one; a count above the store size is clipped to it.
  always_comb begin
    if (active_r == '0) begin
      n_eff = clb_pkg::ACTIVE_W'(1);
    end else if (int'(active_r) > MAX_COLLECTORS) begin
      n_eff = clb_pkg::ACTIVE_W'(MAX_COLLECTORS);
    end else begin
      n_eff = active_r;
    end
  end

  // An entry never written since reset reads as zero sessions.
  assign cnt_rd  = vld_r[addr_r] ? ram_q : '0;
  assign cnt_inc = (cnt_rd == clb_pkg::COUNT_MAX) ? cnt_rd : (cnt_rd + CW'(1));

  // Collectors beyond the packed weight word have weight zero.
  assign weight_cur = (int'(idx_r) < clb_pkg::WEIGHT_COUNT) ?
                      weights_r[clb_pkg::WEIGHT_W*int'(idx_r) +: clb_pkg::WEIGHT_W] : '0;

  assign score       = {{(CW-clb_pkg::DIVIDEND_W){1'b0}}, div_rsp.quotient};
  assign idx_last    = (NW'(idx_r) + NW'(1)) == NW'(n_eff);
  assign take_least  = (idx_r == '0) || (cnt_rd < best_r);
  assign take_weight = (idx_r == '0) || (score > best_r);
  assign rr_sel      = IW'(div_rsp.remainder);
  assign rr_wrap     = (NW'(rr_sel) + NW'(1)) == NW'(n_eff);

  always_comb begin
    state_nxt      = state_r;
    turn_nxt       = turn_r;
    idx_nxt        = idx_r;
    sel_nxt        = sel_r;
    addr_nxt       = addr_r;
    best_nxt       = best_r;
    out_strobe_nxt = 1'b0;
    out_idx_nxt    = out_idx_r;
    out_cv_nxt     = out_cv_r;
    ram_we         = 1'b0;
    ram_wdata      = cnt_inc;
    div_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_kind == clb_pkg::KIND_RELEASE) begin
            // Releases outside the store are dropped.
            if (int'(in_release_index) < MAX_COLLECTORS) begin
              addr_nxt  = IW'(in_release_index);
              state_nxt = ST_REL_RD;
            end
          end else begin
            unique case (mode_r) inside
              clb_pkg::MODE_ROUND_ROBIN: begin
                // The turn is reduced modulo the current count by the divider.
                div_req.start    = 1'b1;
                div_req.dividend = clb_pkg::DIVIDEND_W'(turn_r);
                div_req.divisor  = clb_pkg::DIVISOR_W'(n_eff);
                state_nxt        = ST_RR_DIV;
              end
              clb_pkg::MODE_LEAST, clb_pkg::MODE_WEIGHTED: begin
                idx_nxt   = '0;
                addr_nxt  = '0;
                state_nxt = ST_SCAN_RD;
              end
              clb_pkg::MODE_UNSUPPORTED: begin
                out_strobe_nxt = 1'b1;
                out_idx_nxt    = '0;
                out_cv_nxt     = 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
      end

      ST_RR_DIV: begin
        if (div_rsp.done) begin
          sel_nxt   = rr_sel;
          turn_nxt  = rr_wrap ? '0 : (rr_sel + IW'(1));
          addr_nxt  = rr_sel;
          state_nxt = ST_INC_RD;
        end
      end

      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end

      ST_SCAN_CMP: begin
        if (mode_r == clb_pkg::MODE_WEIGHTED) begin
          div_req.start    = 1'b1;
          div_req.dividend = clb_pkg::DIVIDEND_W'(weight_cur) << clb_pkg::WEIGHT_SHIFT;
          div_req.divisor  = {1'b0, cnt_rd} + clb_pkg::DIVISOR_W'(1);
          state_nxt        = ST_SCAN_DIV;
        end else begin
          if (take_least) begin
            best_nxt = cnt_rd;
            sel_nxt  = idx_r;
          end
          if (idx_last) begin
            addr_nxt  = take_least ? idx_r : sel_r;
            state_nxt = ST_INC_RD;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            addr_nxt  = idx_r + IW'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end

      ST_SCAN_DIV: begin
        if (div_rsp.done) begin
          if (take_weight) begin
            best_nxt = score;
            sel_nxt  = idx_r;
          end
          if (idx_last) begin
            addr_nxt  = take_weight ? idx_r : sel_r;
            state_nxt = ST_INC_RD;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            addr_nxt  = idx_r + IW'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end

      ST_INC_RD: begin
        state_nxt = ST_INC_WR;
      end

      ST_INC_WR: begin
        ram_we         = 1'b1;
        ram_wdata      = cnt_inc;
        out_strobe_nxt = 1'b1;
        out_idx_nxt    = clb_pkg::OUT_INDEX_W'(addr_r);
        out_cv_nxt     = 1'b1;
        state_nxt      = ST_IDLE;
      end

      ST_REL_RD: begin
        state_nxt = ST_REL_WR;
      end

      ST_REL_WR: begin
        // An idle collector stays at zero.
        ram_we    = (cnt_rd != '0);
        ram_wdata = cnt_rd - CW'(1);
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      turn_r       <= '0;
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
      mode_r       <= clb_pkg::MODE_ROUND_ROBIN;
      active_r     <= clb_pkg::ACTIVE_W'(1);
      weights_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      turn_r       <= turn_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (ram_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          clb_pkg::REG_BALANCE_MODE: mode_r    <= cfg_data[clb_pkg::MODE_W-1:0];
          clb_pkg::REG_ACTIVE_COUNT: active_r  <= cfg_data[clb_pkg::ACTIVE_W-1:0];
          clb_pkg::REG_WEIGHTS:      weights_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    sel_r     <= sel_nxt;
    addr_r    <= addr_nxt;
    best_r    <= best_nxt;
    out_idx_r <= out_idx_nxt;
    out_cv_r  <= out_cv_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_chosen_index = out_idx_r;
  assign out_choice_valid = out_cv_r;

  // A result only follows a count update or an unsupported-mode pick.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == ST_INC_WR) || ($past(state_r) == ST_IDLE && $past(start)))
    else $error("result strobe without a finished pick");

  // The shared divider is never restarted while a division is running.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // Division results arrive only while the sequencer waits for them.
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_RR_DIV || state_r == ST_SCAN_DIV))
    else $error("divider result outside a wait state");

  // The collector being counted lies inside the active set.
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INC_WR) |-> (NW'(addr_r) < NW'(n_eff)))
    else $error("chosen collector outside the active set");

endmodule
